// File: rtl/bfr_pkg.sv
// Shared constants and codes of the buffer frame replacement block.
package bfr_pkg;

	localparam int DEF_FRAMES    = 16;
	localparam int DEF_PAGE_BITS = 20;

	localparam int OP_W   = 3;
	localparam int STAT_W = 2;
	localparam int MODE_W = 2;
	localparam int FIU_W  = 5;
	localparam int CNT_W  = 32;
	localparam int PIN_W  = 8;
	localparam int CIDX_W = 1;

	localparam logic [PIN_W-1:0] PIN_MAX   = 8'hFF;
	localparam logic [FIU_W-1:0] FIU_RESET = 5'd16;

	localparam logic [OP_W-1:0] OP_PIN   = 3'd0;
	localparam logic [OP_W-1:0] OP_UNPIN = 3'd1;
	localparam logic [OP_W-1:0] OP_DIRTY = 3'd2;
	localparam logic [OP_W-1:0] OP_FORCE = 3'd3;
	localparam logic [OP_W-1:0] OP_FLUSH = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
	localparam logic [STAT_W-1:0] ST_NO_FRAME = 2'd1;
	localparam logic [STAT_W-1:0] ST_NOT_RES  = 2'd2;
	localparam logic [STAT_W-1:0] ST_NOT_PIN  = 2'd3;

	localparam logic [MODE_W-1:0] MODE_FIFO  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LRU   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CLOCK = 2'd2;

	localparam logic [CIDX_W-1:0] CFG_MODE = 1'b0;
	localparam logic [CIDX_W-1:0] CFG_FIU  = 1'b1;

endpackage

// File: rtl/buffer_frame_replacement.sv
// Buffer pool frame table with FIFO, LRU or CLOCK replacement, one frame memory.
// Sequence: lookup reads and checks each frame in turn (up to frames_in_use), then an act state;
// a pin miss adds a victim scan of read and check steps (up to FRAMES, or 2*frames_in_use under CLOCK)
// and a load state, then the beat is presented. Flush reads and checks each rank in turn
// for all FRAMES ranks, stalls while a beat waits, then presents the last beat. One item at a time.
// Reset clears all frames to empty, ranks to frame order, hand and counters to zero.
module buffer_frame_replacement #(
	parameter int FRAMES    = bfr_pkg::DEF_FRAMES,
	parameter int PAGE_BITS = bfr_pkg::DEF_PAGE_BITS,
	localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [bfr_pkg::OP_W-1:0]     operation,
	input  logic [PAGE_BITS-1:0]         page_number,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [bfr_pkg::STAT_W-1:0]   status,
	output logic [FW-1:0]                frame_index,
	output logic                         hit,
	output logic                         load_request,
	output logic                         writeback_request,
	output logic [PAGE_BITS-1:0]         writeback_page,
	output logic [bfr_pkg::CNT_W-1:0]    read_total,
	output logic [bfr_pkg::CNT_W-1:0]    write_total,
	output logic                         last,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [bfr_pkg::CIDX_W-1:0]   cfg_index,
	input  logic [bfr_pkg::FIU_W-1:0]    cfg_data
);

	localparam int CW = $clog2(FRAMES + 1);
	localparam int SW = CW + 1;

	typedef struct packed {
		logic [PAGE_BITS-1:0]          tag;
		logic                          dirty;
		logic [bfr_pkg::PIN_W-1:0]     pin;
		logic                          refb;
	} entry_t;

	typedef struct packed {
		logic [bfr_pkg::STAT_W-1:0]    status;
		logic [FW-1:0]                 frame;
		logic                          hit;
		logic                          load;
		logic                          wb;
		logic [PAGE_BITS-1:0]          wb_page;
		logic [bfr_pkg::CNT_W-1:0]     rd_total;
		logic [bfr_pkg::CNT_W-1:0]     wr_total;
		logic                          last;
	} res_t;

	typedef enum logic [10:0] {
		S_IDLE   = 11'b00000000001,
		S_LK_RD  = 11'b00000000010,
		S_LK_EV  = 11'b00000000100,
		S_ACT    = 11'b00000001000,
		S_VC_RD  = 11'b00000010000,
		S_VC_EV  = 11'b00000100000,
		S_LOAD   = 11'b00001000000,
		S_FL_RD  = 11'b00010000000,
		S_FL_EV  = 11'b00100000000,
		S_FL_END = 11'b01000000000,
		S_RESP   = 11'b10000000000
	} state_t;

	entry_t                        frame_mem [FRAMES];
	entry_t                        rd_q;
	logic                          rd_vld_q;
	logic [FRAMES-1:0]             valid_q;
	logic [FW-1:0]                 rank_q  [FRAMES];
	logic [FW-1:0]                 order_q [FRAMES];

	state_t                        state_q;
	logic [bfr_pkg::OP_W-1:0]      op_q;
	logic [PAGE_BITS-1:0]          page_q;
	logic [FW-1:0]                 idx_q;
	logic [SW-1:0]                 step_q;
	logic [FW-1:0]                 vf_q;
	logic                          found_q;
	logic [FW-1:0]                 fidx_q;
	entry_t                        fent_q;
	logic                          fvld_q;
	logic [FW-1:0]                 hand_q;
	logic [bfr_pkg::CNT_W-1:0]     load_cnt_q;
	logic [bfr_pkg::CNT_W-1:0]     store_cnt_q;
	logic [bfr_pkg::MODE_W-1:0]    mode_q;
	logic [bfr_pkg::FIU_W-1:0]     fiu_q;
	res_t                          res_q;
	res_t                          pend_q;
	logic                          pend_v_q;
	res_t                          out_q;
	logic                          out_valid_q;

	logic [CW-1:0]                 n_used;
	logic [SW-1:0]                 two_n;
	logic [FW-1:0]                 clk_start;
	logic                          is_clock;
	logic                          is_lru;
	logic                          slot_free;
	entry_t                        d;
	logic                          rd_en;
	logic [FW-1:0]                 rd_addr;
	logic                          wr_en;
	logic [FW-1:0]                 wr_addr;
	entry_t                        wr_data;
	logic                          mn_en;
	logic [FW-1:0]                 mn_old;
	logic                          lk_match;
	logic                          lk_last;
	logic                          vc_pick;
	logic                          vc_fail;
	logic                          fl_hit;
	logic                          fl_take;
	logic                          idx_end;
	logic [FW-1:0]                 idx_wrap;
	logic                          wb_now;
	logic                          out_load;
	res_t                          pend_fin;

	always_comb begin
		if (fiu_q == '0) begin
			n_used = CW'(1);
		end else if (int'(fiu_q) > FRAMES) begin
			n_used = CW'(FRAMES);
		end else begin
			n_used = CW'(fiu_q);
		end
		two_n = {n_used, 1'b0};
		if (CW'(hand_q) < n_used && (CW'(hand_q) + CW'(1)) != n_used) begin
			clk_start = hand_q + FW'(1);
		end else begin
			clk_start = '0;
		end
	end

	always_comb begin
		pend_fin      = pend_q;
		pend_fin.last = 1'b1;
	end

	assign is_clock  = (mode_q == bfr_pkg::MODE_CLOCK);
	assign is_lru    = (mode_q == bfr_pkg::MODE_LRU);
	assign slot_free = !out_valid_q || out_ready;
	assign d         = rd_vld_q ? rd_q : '0;
	assign idx_end   = (idx_q == FW'(FRAMES - 1));
	assign idx_wrap  = ((CW'(idx_q) + CW'(1)) == n_used) ? '0 : idx_q + FW'(1);
	assign lk_match  = rd_vld_q && (rd_q.tag == page_q);
	assign lk_last   = (CW'(idx_q) + CW'(1)) == n_used;
	assign vc_pick   = is_clock ? (d.pin == '0 && !d.refb)
	                            : (CW'(vf_q) < n_used && d.pin == '0);
	assign vc_fail   = !vc_pick && (is_clock ? ((step_q + SW'(1)) == two_n) : idx_end);
	assign fl_hit    = (CW'(vf_q) < n_used) && rd_vld_q && d.dirty;
	assign fl_take   = fl_hit && (!pend_v_q || slot_free);
	assign wb_now    = fvld_q && fent_q.dirty;
	assign mn_old    = rank_q[fidx_q];
	assign out_load  = (state_q == S_FL_EV && fl_take && pend_v_q) ||
	                   ((state_q == S_FL_END || state_q == S_RESP) && slot_free);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = idx_q;
		case (state_q)
			S_LK_RD: begin
				rd_en = 1'b1;
			end
			S_VC_RD: begin
				rd_en   = 1'b1;
				rd_addr = is_clock ? idx_q : order_q[idx_q];
			end
			S_FL_RD: begin
				rd_en   = 1'b1;
				rd_addr = order_q[idx_q];
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = fidx_q;
		wr_data = fent_q;
		mn_en   = 1'b0;
		case (state_q)
			S_ACT: begin
				if (found_q) begin
					case (op_q)
						bfr_pkg::OP_PIN: begin
							wr_en = 1'b1;
							if (fent_q.pin != bfr_pkg::PIN_MAX) begin
								wr_data.pin = fent_q.pin + 1'b1;
							end
							wr_data.refb = 1'b1;
							mn_en        = is_lru;
						end
						bfr_pkg::OP_UNPIN: begin
							wr_en       = (fent_q.pin != '0);
							wr_data.pin = fent_q.pin - 1'b1;
							if (fent_q.pin == bfr_pkg::PIN_W'(1)) begin
								wr_data.refb = 1'b0;
							end
						end
						bfr_pkg::OP_DIRTY: begin
							wr_en         = 1'b1;
							wr_data.dirty = 1'b1;
						end
						bfr_pkg::OP_FORCE: begin
							wr_en         = 1'b1;
							wr_data.dirty = 1'b0;
						end
						default: begin
							wr_en = 1'b0;
						end
					endcase
				end
			end
			S_VC_EV: begin
				if (is_clock && d.pin == '0 && d.refb) begin
					wr_en        = 1'b1;
					wr_addr      = vf_q;
					wr_data      = d;
					wr_data.refb = 1'b0;
				end
			end
			S_LOAD: begin
				wr_en         = 1'b1;
				wr_data.tag   = page_q;
				wr_data.dirty = 1'b0;
				wr_data.pin   = bfr_pkg::PIN_W'(1);
				wr_data.refb  = 1'b1;
				mn_en         = !is_clock;
			end
			S_FL_EV: begin
				if (fl_take) begin
					wr_en         = 1'b1;
					wr_addr       = vf_q;
					wr_data       = d;
					wr_data.dirty = 1'b0;
				end
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			frame_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= frame_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < FRAMES; i++) begin
				rank_q[i]  <= FW'(i);
				order_q[i] <= FW'(i);
			end
		end else if (mn_en) begin
			for (int i = 0; i < FRAMES; i++) begin
				if (rank_q[i] > mn_old) begin
					rank_q[i] <= rank_q[i] - 1'b1;
				end
			end
			rank_q[fidx_q] <= FW'(FRAMES - 1);
			for (int r = 0; r < FRAMES - 1; r++) begin
				if (FW'(r) >= mn_old) begin
					order_q[r] <= order_q[r + 1];
				end
			end
			order_q[FRAMES - 1] <= fidx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			valid_q     <= '0;
			rd_vld_q    <= 1'b0;
			hand_q      <= '0;
			load_cnt_q  <= '0;
			store_cnt_q <= '0;
			mode_q      <= bfr_pkg::MODE_FIFO;
			fiu_q       <= bfr_pkg::FIU_RESET;
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
			found_q     <= 1'b0;
		end else begin
			if (rd_en) begin
				rd_vld_q <= valid_q[rd_addr];
				vf_q     <= rd_addr;
			end
			if (cfg_valid) begin
				case (cfg_index)
					bfr_pkg::CFG_MODE: mode_q <= cfg_data[bfr_pkg::MODE_W-1:0];
					bfr_pkg::CFG_FIU:  fiu_q  <= cfg_data;
					default:           mode_q <= mode_q;
				endcase
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q     <= operation;
						page_q   <= page_number;
						idx_q    <= '0;
						found_q  <= 1'b0;
						pend_v_q <= 1'b0;
						res_q    <= '{status: bfr_pkg::ST_OK, frame: '0, hit: 1'b0,
							load: 1'b0, wb: 1'b0, wb_page: '0, rd_total: load_cnt_q,
							wr_total: store_cnt_q, last: 1'b1};
						if (operation == bfr_pkg::OP_FLUSH) begin
							state_q <= S_FL_RD;
						end else if (operation < bfr_pkg::OP_FLUSH) begin
							state_q <= S_LK_RD;
						end else begin
							state_q <= S_RESP;
						end
					end
				end
				S_LK_RD: begin
					state_q <= S_LK_EV;
				end
				S_LK_EV: begin
					if (lk_match) begin
						found_q <= 1'b1;
						fidx_q  <= idx_q;
						fent_q  <= rd_q;
						state_q <= S_ACT;
					end else if (lk_last) begin
						state_q <= S_ACT;
					end else begin
						idx_q   <= idx_q + FW'(1);
						state_q <= S_LK_RD;
					end
				end
				S_ACT: begin
					if (!found_q) begin
						if (op_q == bfr_pkg::OP_PIN) begin
							idx_q   <= is_clock ? clk_start : '0;
							step_q  <= '0;
							state_q <= S_VC_RD;
						end else begin
							res_q.status <= bfr_pkg::ST_NOT_RES;
							state_q      <= S_RESP;
						end
					end else begin
						state_q     <= S_RESP;
						res_q.frame <= fidx_q;
						case (op_q)
							bfr_pkg::OP_PIN: begin
								res_q.hit <= 1'b1;
							end
							bfr_pkg::OP_UNPIN: begin
								if (fent_q.pin == '0) begin
									res_q.status <= bfr_pkg::ST_NOT_PIN;
								end
							end
							bfr_pkg::OP_FORCE: begin
								store_cnt_q    <= store_cnt_q + 1'b1;
								res_q.wb       <= 1'b1;
								res_q.wb_page  <= fent_q.tag;
								res_q.wr_total <= store_cnt_q + 1'b1;
							end
							default: begin
								res_q.hit <= 1'b0;
							end
						endcase
					end
				end
				S_VC_RD: begin
					state_q <= S_VC_EV;
				end
				S_VC_EV: begin
					if (vc_pick) begin
						fidx_q  <= vf_q;
						fent_q  <= d;
						fvld_q  <= rd_vld_q;
						state_q <= S_LOAD;
					end else if (vc_fail) begin
						res_q.status <= bfr_pkg::ST_NO_FRAME;
						state_q      <= S_RESP;
					end else begin
						step_q  <= step_q + SW'(1);
						idx_q   <= is_clock ? idx_wrap : idx_q + FW'(1);
						state_q <= S_VC_RD;
					end
				end
				S_LOAD: begin
					valid_q[fidx_q] <= 1'b1;
					load_cnt_q      <= load_cnt_q + 1'b1;
					store_cnt_q     <= store_cnt_q + bfr_pkg::CNT_W'(wb_now);
					if (is_clock) begin
						hand_q <= fidx_q;
					end
					res_q.frame    <= fidx_q;
					res_q.load     <= 1'b1;
					res_q.wb       <= wb_now;
					res_q.wb_page  <= wb_now ? fent_q.tag : '0;
					res_q.rd_total <= load_cnt_q + 1'b1;
					res_q.wr_total <= store_cnt_q + bfr_pkg::CNT_W'(wb_now);
					state_q        <= S_RESP;
				end
				S_FL_RD: begin
					state_q <= S_FL_EV;
				end
				S_FL_EV: begin
					if (!fl_hit || fl_take) begin
						if (fl_take) begin
							if (pend_v_q) begin
								out_q <= pend_q;
							end
							store_cnt_q <= store_cnt_q + 1'b1;
							pend_v_q    <= 1'b1;
							pend_q      <= '{status: bfr_pkg::ST_OK, frame: vf_q, hit: 1'b0,
								load: 1'b0, wb: 1'b1, wb_page: d.tag, rd_total: load_cnt_q,
								wr_total: store_cnt_q + 1'b1, last: 1'b0};
						end
						if (idx_end) begin
							state_q <= S_FL_END;
						end else begin
							idx_q   <= idx_q + FW'(1);
							state_q <= S_FL_RD;
						end
					end
				end
				S_FL_END: begin
					if (slot_free) begin
						if (pend_v_q) begin
							out_q <= pend_fin;
						end else begin
							out_q <= res_q;
						end
						state_q <= S_IDLE;
					end
				end
				S_RESP: begin
					if (slot_free) begin
						out_q   <= res_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready          = (state_q == S_IDLE);
	assign cfg_ready         = 1'b1;
	assign out_valid         = out_valid_q;
	assign status            = out_q.status;
	assign frame_index       = out_q.frame;
	assign hit               = out_q.hit;
	assign load_request      = out_q.load;
	assign writeback_request = out_q.wb;
	assign writeback_page    = out_q.wb_page;
	assign read_total        = out_q.rd_total;
	assign write_total       = out_q.wr_total;
	assign last              = out_q.last;

`ifndef SYNTH
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q != S_IDLE)
		else $error("accepted beat did not start work");

	a_store_step: assert property (@(posedge clk) disable iff (!arst_n)
		(store_cnt_q == $past(store_cnt_q)) || (store_cnt_q == $past(store_cnt_q) + 1'b1))
		else $error("write count jumped");

	a_rank_order: assert property (@(posedge clk) disable iff (!arst_n)
		rank_q[order_q[0]] == '0)
		else $error("age order and rank disagree");
`endif

endmodule
